@@ rtl/core/sf3_pkg.sv @@
// Shared types, constants and the per-channel kernel function of the 3x3 stencil filter.
// Used by every module in rtl/core except sf3_ram; depends on nothing else.
package sf3_pkg;

  // Default frame limits for the top-level parameters
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  // Field widths
  localparam int CHAN_W = 8;
  localparam int PIX_W  = 3 * CHAN_W;
  localparam int LINE_W = 2 * PIX_W;   // one line store entry: {row above, current row}
  localparam int CFG_W  = 11;
  localparam int MODE_W = 2;
  localparam int ADDR_W = 2;

  // Configuration register indexes
  localparam logic [ADDR_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [ADDR_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [ADDR_W-1:0] REG_MODE   = 2'd2;

  // Filter modes
  localparam logic [MODE_W-1:0] MODE_BOX     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SHARPEN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_EDGE    = 2'd2;

  // Kernel constants; box divide is a reciprocal multiply
  localparam int BOX_DIV     = 9;
  localparam int SHARPEN_GAIN = 5;
  localparam int EDGE_GAIN   = 8;
  localparam int BOX_SHIFT   = 16;
  localparam int BOX_RECIP   = ((1 << BOX_SHIFT) + BOX_DIV - 1) / BOX_DIV;

  // Result queue depth
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PW    = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

  // Pixel, red in the low byte
  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } rgb_t;

  // Per-item control decided at accept time
  typedef struct packed {
    logic emit;
    logic border;
    logic row_end;
    logic frame_end;
  } flags_t;

  // One result item
  typedef struct packed {
    logic frame_end;
    logic row_end;
    rgb_t pix;
  } out_t;

  // Nine taps of one channel, tap 4 is the center
  typedef logic [8:0][CHAN_W-1:0] taps9_t;

  // Filter one channel of the window center
  function automatic logic [CHAN_W-1:0] filter_chan(logic [MODE_W-1:0] mode, taps9_t t);
    logic [9:0]        cross_sum;
    logic [9:0]        diag;
    logic [11:0]       total;
    logic [24:0]       prod;
    logic signed [12:0] acc;
    logic [CHAN_W-1:0] res;
    cross_sum = 10'(t[1]) + 10'(t[3]) + 10'(t[5]) + 10'(t[7]);
    diag  = 10'(t[0]) + 10'(t[2]) + 10'(t[6]) + 10'(t[8]);
    total = 12'(cross_sum) + 12'(diag) + 12'(t[4]);
    prod  = 25'(total) * 25'(BOX_RECIP);
    acc   = '0;
    res   = t[4];
    case (mode)
      MODE_BOX: begin
        res = prod[BOX_SHIFT +: CHAN_W];
      end
      MODE_SHARPEN: begin
        acc = 13'(13'(t[4]) * 13'(SHARPEN_GAIN) - 13'(cross_sum));
      end
      MODE_EDGE: begin
        acc = 13'(13'(t[4]) * 13'(EDGE_GAIN) - 13'(cross_sum) - 13'(diag));
      end
      default: begin
        res = t[4];
      end
    endcase
    // clamp signed kernels to 0..255
    if (mode == MODE_SHARPEN || mode == MODE_EDGE) begin
      if (acc < 13'sd0) begin
        res = '0;
      end else if (acc > 13'sd255) begin
        res = '1;
      end else begin
        res = acc[CHAN_W-1:0];
      end
    end
    return res;
  endfunction

endpackage

@@ rtl/core/stencil_filter_3x3_rgb.sv @@
// 3x3 stencil filter (box blur, sharpen, edge detect) on a raster RGB stream.
// Top level; depends on sf3_pkg, sf3_ctrl, sf3_win, sf3_outq and sf3_ram.
//
// Usage:
//   Input channel in_*: one pixel per transfer in raster order, in_tuser marks a
//   flush item. Once a whole frame is in, every further item (pixel data
//   discarded) or flush pushes one more result out; width+1 of them drain the
//   frame. A flush sent before the frame is complete is dropped.
//   Output channel out_*: one result per emitted pixel, trailing the input
//   stream by width+1 items; out_tlast marks the last pixel of a row, out_tuser
//   the last pixel of the frame. Border pixels pass through unfiltered.
//   Configuration port cfg_*: write width, height and mode while the block is idle.
// Timing:
//   One item per clock sustained while out_tready is high. The item that releases
//   a result goes through the line store read, then the window, then the queue.
//   The line store is one RAM word per column holding both previous rows, read
//   and rewritten once per item; a bypass covers back-to-back hits on one entry.
// Reset and stalls:
//   rst_n clears counters, window and queue; the line store needs no clearing.
//   A four-entry result queue absorbs the pipeline when out_tready is low;
//   in_tready drops once the queue plus items in flight would fill it.
module stencil_filter_3x3_rgb #(
  parameter int MAX_WIDTH  = sf3_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sf3_pkg::MAX_HEIGHT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [23:0]                 in_tdata,   // red_in, green_in, blue_in
  input  logic                        in_tuser,   // kind
  // output channel
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [23:0]                 out_tdata,  // red_out, green_out, blue_out
  output logic                        out_tlast,  // row_end
  output logic                        out_tuser,  // frame_end
  // configuration
  input  logic                        cfg_we,
  input  logic [sf3_pkg::ADDR_W-1:0]  cfg_addr,
  input  logic [sf3_pkg::CFG_W-1:0]   cfg_wdata
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic [sf3_pkg::CFG_W-1:0]    cfg_width_r;
  logic [sf3_pkg::CFG_W-1:0]    cfg_height_r;
  logic [sf3_pkg::MODE_W-1:0]   cfg_mode_r;

  logic                         accept;
  logic                         iss_valid;
  logic [AW-1:0]                iss_addr;
  sf3_pkg::rgb_t                iss_pix;
  sf3_pkg::flags_t              iss_flags;
  logic                         s1_valid;
  logic                         s2_valid;
  sf3_pkg::out_t                res;
  sf3_pkg::out_t                head;
  logic [sf3_pkg::OUTQ_CW-1:0]  q_count;
  logic [sf3_pkg::OUTQ_CW-1:0]  occupancy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= sf3_pkg::CFG_W'(1024);
      cfg_height_r <= sf3_pkg::CFG_W'(1024);
      cfg_mode_r   <= sf3_pkg::MODE_BOX;
    end else if (cfg_we) begin
      case (cfg_addr)
        sf3_pkg::REG_WIDTH:  cfg_width_r  <= cfg_wdata;
        sf3_pkg::REG_HEIGHT: cfg_height_r <= cfg_wdata;
        sf3_pkg::REG_MODE:   cfg_mode_r   <= cfg_wdata[sf3_pkg::MODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Flow control: queue entries plus items still in the pipeline
  assign occupancy = q_count + sf3_pkg::OUTQ_CW'(s1_valid) + sf3_pkg::OUTQ_CW'(s2_valid);
  assign in_tready = rst_n && (occupancy < sf3_pkg::OUTQ_CW'(sf3_pkg::OUTQ_DEPTH));
  assign accept    = in_tvalid && in_tready;

  sf3_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_width  (cfg_width_r),
    .cfg_height (cfg_height_r),
    .accept     (accept),
    .flush      (in_tuser),
    .pix        (sf3_pkg::rgb_t'(in_tdata)),
    .iss_valid  (iss_valid),
    .iss_addr   (iss_addr),
    .iss_pix    (iss_pix),
    .iss_flags  (iss_flags)
  );

  sf3_win #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_win (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (cfg_mode_r),
    .iss_valid (iss_valid),
    .iss_addr  (iss_addr),
    .iss_pix   (iss_pix),
    .iss_flags (iss_flags),
    .s1_valid  (s1_valid),
    .s2_valid  (s2_valid),
    .res       (res)
  );

  sf3_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s2_valid),
    .push_data (res),
    .pop       (out_tready),
    .valid     (out_tvalid),
    .head      (head),
    .count     (q_count)
  );

  assign out_tdata = head.pix;
  assign out_tlast = head.row_end;
  assign out_tuser = head.frame_end;

  // Queue never has to take more than it holds
  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    occupancy <= sf3_pkg::OUTQ_CW'(sf3_pkg::OUTQ_DEPTH))
    else $error("result queue over-committed");

  // Frame end is always also a row end
  a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("frame end without row end");

  // A filtered result comes only from an item that went through the line store
  a_s2_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(s2_valid) |-> $past(s1_valid))
    else $error("window stage valid without line store stage");

endmodule

@@ rtl/core/sf3_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Read-during-write to the same address returns the old contents. No dependencies.
module sf3_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/sf3_ctrl.sv @@
// Raster position tracking for the 3x3 stencil filter: input and output counters,
// flush handling and per-item flags. Depends on sf3_pkg.
module sf3_ctrl #(
  parameter int MAX_WIDTH  = sf3_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sf3_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [sf3_pkg::CFG_W-1:0]         cfg_width,
  input  logic [sf3_pkg::CFG_W-1:0]         cfg_height,
  input  logic                              accept,
  input  logic                              flush,
  input  sf3_pkg::rgb_t                     pix,
  output logic                              iss_valid,
  output logic [$clog2(MAX_WIDTH)-1:0]      iss_addr,
  output sf3_pkg::rgb_t                     iss_pix,
  output sf3_pkg::flags_t                   iss_flags
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);

  logic [CW-1:0] in_col_r, in_col_nxt;
  logic [RW-1:0] in_row_r, in_row_nxt;
  logic [CW-1:0] out_col_r, out_col_nxt;
  logic [RW-1:0] out_row_r, out_row_nxt;

  logic [CW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic [CW-1:0] w_m1;
  logic [RW-1:0] h_m1;
  logic [CW-1:0] col_inc;
  logic          draining;
  logic          take;
  logic          emit;
  logic          rend;
  logic          last_row;
  logic          fend;
  logic          border;

  // Clamp configured sizes to 1..MAX
  always_comb begin
    if (cfg_width == '0) begin
      eff_w = CW'(1);
    end else if (32'(cfg_width) > 32'(MAX_WIDTH)) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = CW'(cfg_width);
    end
    if (cfg_height == '0) begin
      eff_h = HW'(1);
    end else if (32'(cfg_height) > 32'(MAX_HEIGHT)) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(cfg_height);
    end
  end

  // Position decode
  assign w_m1     = eff_w - CW'(1);
  assign h_m1     = RW'(eff_h) - RW'(1);
  assign col_inc  = in_col_r + CW'(1);
  assign draining = in_row_r >= RW'(eff_h);
  assign take     = accept && (draining || !flush);
  assign emit     = (in_row_r >= RW'(2)) || (in_row_r == RW'(1) && in_col_r != '0);
  assign rend     = out_col_r >= w_m1;
  assign last_row = out_row_r >= h_m1;
  assign fend     = rend && last_row;
  assign border   = out_row_r == '0 || out_col_r == '0 || last_row || rend;

  // Issue to the line store stage
  assign iss_valid           = take;
  assign iss_addr            = in_col_r[AW-1:0];
  assign iss_pix             = draining ? '0 : pix;
  assign iss_flags.emit      = emit;
  assign iss_flags.border    = border;
  assign iss_flags.row_end   = rend;
  assign iss_flags.frame_end = fend;

  // Counter updates
  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (take) begin
      if (col_inc >= eff_w) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + RW'(1);
      end else begin
        in_col_nxt = col_inc;
      end
      if (emit) begin
        if (fend) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (rend) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + RW'(1);
        end else begin
          out_col_nxt = out_col_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

endmodule

@@ rtl/core/sf3_win.sv @@
// Line store read-modify-write, 3x3 window shift and kernel evaluation.
// Depends on sf3_pkg and sf3_ram.
module sf3_win #(
  parameter int MAX_WIDTH = sf3_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [sf3_pkg::MODE_W-1:0]   mode,
  input  logic                         iss_valid,
  input  logic [$clog2(MAX_WIDTH)-1:0] iss_addr,
  input  sf3_pkg::rgb_t                iss_pix,
  input  sf3_pkg::flags_t              iss_flags,
  output logic                         s1_valid,
  output logic                         s2_valid,
  output sf3_pkg::out_t                res
);

  localparam int AW = $clog2(MAX_WIDTH);

  // Stage 1: line store data returning
  logic                          s1_valid_r;
  logic [AW-1:0]                 s1_addr_r;
  sf3_pkg::rgb_t                 s1_pix_r;
  sf3_pkg::flags_t               s1_flags_r;

  // Bypass for a write that lands on the edge its own address is read again
  logic                          fwd_hit_r, fwd_hit_nxt;
  logic [sf3_pkg::LINE_W-1:0]    fwd_data_r;

  // Stage 2: window holds the item to filter
  logic                          s2_valid_r;
  sf3_pkg::flags_t               s2_flags_r;
  sf3_pkg::rgb_t                 window_r [9];

  logic [sf3_pkg::LINE_W-1:0]    ram_rdata;
  logic [sf3_pkg::LINE_W-1:0]    line;
  logic [sf3_pkg::LINE_W-1:0]    wr_data;
  sf3_pkg::rgb_t                 top_px;
  sf3_pkg::rgb_t                 mid_px;
  sf3_pkg::taps9_t               taps_r;
  sf3_pkg::taps9_t               taps_g;
  sf3_pkg::taps9_t               taps_b;

  sf3_ram #(
    .WIDTH (sf3_pkg::LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_addr_r),
    .wdata (wr_data),
    .re    (iss_valid),
    .raddr (iss_addr),
    .rdata (ram_rdata)
  );

  // Entry is {row above, current row}; current row moves up, new pixel enters
  assign line    = fwd_hit_r ? fwd_data_r : ram_rdata;
  assign top_px  = line[sf3_pkg::LINE_W-1:sf3_pkg::PIX_W];
  assign mid_px  = line[sf3_pkg::PIX_W-1:0];
  assign wr_data = {mid_px, s1_pix_r};
  assign fwd_hit_nxt = s1_valid_r && iss_valid && (iss_addr == s1_addr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
      s2_valid_r <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        window_r[i] <= '0;
      end
    end else begin
      s1_valid_r <= iss_valid;
      fwd_hit_r  <= fwd_hit_nxt;
      s2_valid_r <= s1_valid_r && s1_flags_r.emit;
      if (s1_valid_r) begin
        window_r[0] <= window_r[1];
        window_r[1] <= window_r[2];
        window_r[2] <= top_px;
        window_r[3] <= window_r[4];
        window_r[4] <= window_r[5];
        window_r[5] <= mid_px;
        window_r[6] <= window_r[7];
        window_r[7] <= window_r[8];
        window_r[8] <= s1_pix_r;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (iss_valid) begin
      s1_addr_r  <= iss_addr;
      s1_pix_r   <= iss_pix;
      s1_flags_r <= iss_flags;
    end
    if (fwd_hit_nxt) begin
      fwd_data_r <= wr_data;
    end
    if (s1_valid_r) begin
      s2_flags_r <= s1_flags_r;
    end
  end

  // Kernel on the window
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      taps_r[i] = window_r[i].red;
      taps_g[i] = window_r[i].green;
      taps_b[i] = window_r[i].blue;
    end
  end

  always_comb begin
    res.row_end   = s2_flags_r.row_end;
    res.frame_end = s2_flags_r.frame_end;
    if (s2_flags_r.border) begin
      res.pix = window_r[4];
    end else begin
      res.pix.red   = sf3_pkg::filter_chan(mode, taps_r);
      res.pix.green = sf3_pkg::filter_chan(mode, taps_g);
      res.pix.blue  = sf3_pkg::filter_chan(mode, taps_b);
    end
  end

  assign s1_valid = s1_valid_r;
  assign s2_valid = s2_valid_r;

endmodule

@@ rtl/core/sf3_outq.sv @@
// Small result queue between the filter pipeline and the output channel.
// Depends on sf3_pkg.
module sf3_outq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  sf3_pkg::out_t                push_data,
  input  logic                         pop,
  output logic                         valid,
  output sf3_pkg::out_t                head,
  output logic [sf3_pkg::OUTQ_CW-1:0]  count
);

  sf3_pkg::out_t                 mem_r [sf3_pkg::OUTQ_DEPTH];
  logic [sf3_pkg::OUTQ_PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [sf3_pkg::OUTQ_PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [sf3_pkg::OUTQ_CW-1:0]   count_r, count_nxt;
  logic                          do_pop;

  assign do_pop = pop && (count_r != '0);

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push   ? wr_ptr_r + sf3_pkg::OUTQ_PW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + sf3_pkg::OUTQ_PW'(1) : rd_ptr_r;
    count_nxt  = count_r + sf3_pkg::OUTQ_CW'(push) - sf3_pkg::OUTQ_CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign valid = count_r != '0;
  assign head  = mem_r[rd_ptr_r];
  assign count = count_r;

endmodule

@@ verif/tb_stencil_filter_3x3_rgb.sv @@
// Self-checking testbench for stencil_filter_3x3_rgb: directed sharpen frame, extreme sizes
// with a long output stall, then random frames in all modes with random idling.
// Depends on sf3_pkg and the RTL under rtl/core only.
module tb;
  import sf3_pkg::*;

  localparam int MAX_W         = MAX_WIDTH_DEF;
  localparam int MAX_H         = MAX_HEIGHT_DEF;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_CYCLES  = 300;
  localparam int RANDOM_ITEMS  = 400;
  localparam int GAP_PCT       = 26;

  // index with no register behind it, and the mode with no kernel
  localparam logic [ADDR_W-1:0] REG_SPARE = 2'd3;
  localparam logic [MODE_W-1:0] MODE_PASS = 2'd3;

  // directed 4x3 frame: bright spots at pixels 2, 5 and 10
  localparam logic [11:0]    HOT_SPOTS = 12'b0100_0010_0100;
  localparam logic [PIX_W-1:0] HOT_PIX  = 24'hFF00FF;  // red and blue full, green zero
  localparam logic [PIX_W-1:0] COLD_PIX = 24'h00FF00;

  // Predicts the filtered pixel stream and checks results in order
  class stencil_scoreboard;
    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    logic [MODE_W-1:0] mode_reg;
    logic [PIX_W-1:0]  line_mem [2*MAX_W];
    logic [PIX_W-1:0]  win [9];
    int unsigned       in_col, in_row, out_col, out_row;
    out_t              pending_pixels [$];
    int unsigned       items_taken, flushes_dropped, results_seen, frames_done, errors;

    function new();
      width_reg  = CFG_W'(MAX_W);
      height_reg = CFG_W'(MAX_H);
      mode_reg   = MODE_BOX;
      foreach (line_mem[i]) line_mem[i] = '0;
      foreach (win[i]) win[i] = '0;
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
      items_taken = 0;
      flushes_dropped = 0;
      results_seen = 0;
      frames_done = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [ADDR_W-1:0] addr, logic [CFG_W-1:0] data);
      case (addr)
        REG_WIDTH:  width_reg = data;
        REG_HEIGHT: height_reg = data;
        REG_MODE:   mode_reg = data[MODE_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_W) return MAX_W;
      return 32'(width_reg);
    endfunction

    function int unsigned eff_height();
      if (height_reg == 0) return 1;
      if (height_reg > MAX_H) return MAX_H;
      return 32'(height_reg);
    endfunction

    function bit frame_loaded();
      return in_row >= eff_height();
    endfunction

    function int tap(int k, int ch);
      return int'(win[k][CHAN_W*ch +: CHAN_W]);
    endfunction

    // kernel on one channel of the window center, clamped to 0..255
    function logic [CHAN_W-1:0] filter_channel(int ch);
      int c, cross_sum, diag, acc;
      c     = tap(4, ch);
      cross_sum = tap(1, ch) + tap(3, ch) + tap(5, ch) + tap(7, ch);
      diag  = tap(0, ch) + tap(2, ch) + tap(6, ch) + tap(8, ch);
      case (mode_reg)
        MODE_BOX:     acc = (c + cross_sum + diag) / BOX_DIV;
        MODE_SHARPEN: acc = SHARPEN_GAIN * c - cross_sum;
        MODE_EDGE:    acc = EDGE_GAIN * c - cross_sum - diag;
        default:      acc = c;
      endcase
      if (acc < 0) return '0;
      if (acc > 255) return '1;
      return acc[CHAN_W-1:0];
    endfunction

    // one accepted input transfer; queues the result it releases, if any
    function void take_item(bit flush, logic [PIX_W-1:0] px);
      int unsigned      w, h, ic;
      logic [PIX_W-1:0] pix, top, mid, res;
      bit               emit, border, rend, fend;
      w   = eff_width();
      h   = eff_height();
      ic  = in_col;
      pix = px;
      top = '0;
      mid = '0;
      if (in_row < h) begin
        if (flush) begin
          flushes_dropped++;
          return;
        end
      end else begin
        pix = '0;
      end
      items_taken++;

      if (ic < MAX_W) begin
        top = line_mem[ic];
        mid = line_mem[MAX_W + ic];
        line_mem[ic] = mid;
        line_mem[MAX_W + ic] = pix;
      end
      win[0] = win[1]; win[1] = win[2]; win[2] = top;
      win[3] = win[4]; win[4] = win[5]; win[5] = mid;
      win[6] = win[7]; win[7] = win[8]; win[8] = pix;

      emit = (in_row >= 2) || (in_row == 1 && ic >= 1);
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      if (!emit) return;

      border = out_row == 0 || out_col == 0 || out_row >= h - 1 || out_col >= w - 1;
      rend   = out_col >= w - 1;
      fend   = rend && out_row >= h - 1;
      for (int ch = 0; ch < 3; ch++) begin
        res[CHAN_W*ch +: CHAN_W] = border ? win[4][CHAN_W*ch +: CHAN_W] : filter_channel(ch);
      end
      pending_pixels.push_back(out_t'({fend, rend, res}));

      if (fend) begin
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
        frames_done++;
      end else if (rend) begin
        out_col = 0;
        out_row++;
      end else begin
        out_col++;
      end
    endfunction

    // one accepted output transfer against the oldest prediction
    function void check_pixel(out_t got);
      out_t want;
      bit   bad;
      results_seen++;
      if (pending_pixels.size() == 0) begin
        if (errors < 10)
          $display("result %0d unexpected: r %h g %h b %h row_end %b frame_end %b",
                   results_seen, got.pix.red, got.pix.green, got.pix.blue,
                   got.row_end, got.frame_end);
        errors++;
        return;
      end
      want = pending_pixels.pop_front();
      bad = got.pix.red !== want.pix.red || got.pix.green !== want.pix.green ||
            got.pix.blue !== want.pix.blue || got.row_end !== want.row_end ||
            got.frame_end !== want.frame_end;
      if (bad) begin
        if (errors < 10) begin
          $display("result %0d mismatch: expected r %h g %h b %h row_end %b frame_end %b",
                   results_seen, want.pix.red, want.pix.green, want.pix.blue,
                   want.row_end, want.frame_end);
          $display("  got r %h g %h b %h row_end %b frame_end %b",
                   got.pix.red, got.pix.green, got.pix.blue, got.row_end, got.frame_end);
        end
        errors++;
      end
    endfunction

    function bit failed();
      return errors != 0 || pending_pixels.size() != 0;
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid;
  logic               in_tready;
  logic [23:0]        in_tdata;   // red_in, green_in, blue_in
  logic               in_tuser;   // kind
  logic               out_tvalid;
  logic               out_tready;
  logic [23:0]        out_tdata;  // red_out, green_out, blue_out
  logic               out_tlast;  // row_end
  logic               out_tuser;  // frame_end
  logic               cfg_we;
  logic [ADDR_W-1:0]  cfg_addr;
  logic [CFG_W-1:0]   cfg_wdata;

  stencil_scoreboard  sb;
  bit                 calm = 1'b0;          // no idling on either side while set
  bit                 stall_request = 1'b0;
  bit                 stall_done = 1'b0;
  int unsigned        cycle_count = 0;

  stencil_filter_3x3_rgb dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, sb.pending_pixels.size());
      $display("stencil_filter_3x3_rgb regression: fail");
      $finish;
    end
  end

  // output monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_pixel(out_t'({out_tuser, out_tlast, out_tdata}));
    end
  end

  function automatic bit take_gap();
    return !calm && ($urandom_range(0, 99) < GAP_PCT);
  endfunction

  // channels pinned to 0 or 255 in extreme_pct percent of cases
  function automatic logic [PIX_W-1:0] random_pixel(int extreme_pct);
    logic [PIX_W-1:0] p;
    for (int ch = 0; ch < 3; ch++) begin
      if ($urandom_range(0, 99) < extreme_pct)
        p[CHAN_W*ch +: CHAN_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      else
        p[CHAN_W*ch +: CHAN_W] = CHAN_W'($urandom_range(0, 255));
    end
    return p;
  endfunction

  // receiver: random back-pressure, one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_request && !stall_done) begin
        out_tready <= 1'b0;
        repeat (STALL_CYCLES) @(negedge clk);
        stall_done = 1'b1;
      end
      out_tready <= !take_gap();
    end
  end

  // one input transfer, with random gaps ahead of it
  task automatic send_item(input bit flush, input logic [PIX_W-1:0] px);
    @(negedge clk);
    while (take_gap()) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= flush;
    in_tdata  <= px;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.take_item(flush, px);
  endtask

  // drop valid, let every prediction arrive, then let the pipeline settle
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(addr, data);
  endtask

  // mode word carries random upper bits, only the low two count
  task automatic configure(input int unsigned w, input int unsigned h,
                           input logic [MODE_W-1:0] mode);
    wait_idle();
    write_reg(REG_WIDTH, CFG_W'(w));
    write_reg(REG_HEIGHT, CFG_W'(h));
    write_reg(REG_MODE, {(CFG_W-MODE_W)'($urandom_range(0, 511)), mode});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // all pixels of a frame, with stray early flushes mixed in
  task automatic load_frame(input int noise_pct);
    while (!sb.frame_loaded()) begin
      if ($urandom_range(0, 99) < noise_pct) send_item(1'b1, random_pixel(30));
      send_item(1'b0, random_pixel(30));
    end
  endtask

  // push the tail of the frame out with flushes and throwaway pixels
  task automatic drain_frame();
    int unsigned done_before;
    done_before = sb.frames_done;
    while (sb.frames_done == done_before) begin
      send_item(1'($urandom_range(0, 1)), random_pixel(30));
    end
  endtask

  // stimulus
  initial begin
    int unsigned start_items;
    int unsigned w_pick, h_pick, r;
    sb = new();
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = REG_WIDTH;
    cfg_wdata = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // sharpen on a 4x3 frame: both interior pixels clamp at both ends, one
    // high on red and blue, the other high on green; early flushes are dropped
    configure(4, 3, MODE_SHARPEN);
    send_item(1'b1, '1);
    for (int i = 0; i < 12; i++) begin
      if (i == 6) send_item(1'b1, '0);
      send_item(1'b0, HOT_SPOTS[i] ? HOT_PIX : COLD_PIX);
    end
    drain_frame();

    // tallest frame (width clamped from zero, height from all ones), unused mode,
    // no idling; a long output hold-off fills the block
    calm = 1'b1;
    configure(0, (1 << CFG_W) - 1, MODE_PASS);
    stall_request = 1'b1;
    load_frame(5);
    drain_frame();
    calm = 1'b0;

    // unused register index must have no effect
    wait_idle();
    write_reg(REG_SPARE, '1);
    @(negedge clk);
    cfg_we <= 1'b0;

    // random frames: mostly small, some degenerate or wide
    start_items = sb.items_taken;
    while (sb.items_taken - start_items < RANDOM_ITEMS) begin
      r = $urandom_range(0, 19);
      if (r == 0) w_pick = 0;
      else if (r == 1) w_pick = $urandom_range(13, 40);
      else w_pick = $urandom_range(1, 12);
      h_pick = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
      configure(w_pick, h_pick, MODE_W'($urandom_range(0, 3)));
      load_frame(8);
      drain_frame();
    end

    wait_idle();
    $display("covered %0d frames over four modes and extreme sizes, %0d items taken,",
             sb.frames_done, sb.items_taken);
    $display("%0d early flushes, %0d results checked, %0d mismatches",
             sb.flushes_dropped, sb.results_seen, sb.errors);
    if (sb.failed()) begin
      $display("stencil_filter_3x3_rgb regression: fail");
    end else begin
      $display("stencil_filter_3x3_rgb regression: pass");
    end
    $finish;
  end

endmodule
